>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge, held off while in reset.
`define ASSERT_ON(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_ON(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

>>> sv/cbm_pkg.sv
`default_nettype none

package cbm_pkg;

	localparam int RAM_BYTES     = 32768;
	localparam int ROM_BANK_BITS = 7;
	localparam int RAM_AW        = $clog2(RAM_BYTES);

	// Bus regions, decoded from address bits 15:13
	localparam logic [2:0] REGION_RAM_EN   = 3'b000; // 0x0000-0x1FFF
	localparam logic [2:0] REGION_ROM_LOW  = 3'b001; // 0x2000-0x3FFF
	localparam logic [2:0] REGION_RAM_BANK = 3'b010; // 0x4000-0x5FFF
	localparam logic [2:0] REGION_MODE     = 3'b011; // 0x6000-0x7FFF
	localparam logic [2:0] REGION_EXT_RAM  = 3'b101; // 0xA000-0xBFFF

	localparam logic [3:0] RAM_EN_KEY = 4'hA;
	localparam logic [7:0] OPEN_BUS   = 8'hFF;

	typedef enum logic {
		CMD_READ  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_ROM_BANKS_LOG2 = 1'b0,
		REG_RAM_SIZE       = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic        command;
		logic [15:0] address;
		logic [7:0]  write_data;
	} access_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        rom_fetch;
		logic [20:0] rom_address;
		logic        status;
	} result_t;

	typedef struct packed {
		logic       ram_enabled;
		logic [6:0] rom_bank;
		logic [1:0] ram_bank;
		logic       rom_mode;
	} map_state_t;

	typedef struct packed {
		result_t           res;
		logic              ram_read;
		logic              ram_we;
		logic [RAM_AW-1:0] ram_addr;
		map_state_t        next;
	} map_out_t;

endpackage

`default_nettype wire

>>> sv/cbm_ifs.sv
`default_nettype none

interface cbm_access_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [15:0] address;
	logic [7:0]  write_data;

	modport source (output valid, command, address, write_data, input ready);
	modport sink   (input valid, command, address, write_data, output ready);
endinterface

interface cbm_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic        rom_fetch;
	logic [20:0] rom_address;
	logic        status;

	modport source (output valid, read_data, rom_fetch, rom_address, status, input ready);
	modport sink   (input valid, read_data, rom_fetch, rom_address, status, output ready);
endinterface

`default_nettype wire

>>> sv/cbm_ram.sv
`default_nettype none

module cbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32768
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/cbm_map.sv
`default_nettype none

module cbm_map import cbm_pkg::*; (
	input  wire access_t    item,
	input  wire map_state_t st,
	input  wire logic [2:0] rom_banks_log2,
	input  wire logic [15:0] ram_size,
	output map_out_t        mo
);

	function automatic logic [6:0] fit_bank(input logic [6:0] b, input logic [6:0] mask);
		logic [6:0] m;
		m = b & mask;
		return (m == 7'd0) ? 7'd1 : m;
	endfunction

	logic [2:0]  bank_log2;
	logic [6:0]  bank_mask;
	logic [15:0] ram_limit;
	logic [14:0] ram_a;
	logic        ram_ok;
	logic        rom_ok;
	logic [4:0]  low_wr;
	logic [4:0]  low_cur;

	always_comb begin
		bank_log2 = (rom_banks_log2 > 3'(ROM_BANK_BITS)) ? 3'(ROM_BANK_BITS) : rom_banks_log2;
		bank_mask = 7'((8'd1 << bank_log2) - 8'd1);
		ram_limit = (ram_size > 16'(RAM_BYTES)) ? 16'(RAM_BYTES) : ram_size;
		ram_a     = {st.ram_bank, item.address[12:0]};
		ram_ok    = st.ram_enabled && ({1'b0, ram_a} < ram_limit);
		// switched bank lies inside the ROM when no bit above the bank count is set
		rom_ok    = (st.rom_bank & ~bank_mask) == 7'd0;
		low_wr    = (item.write_data[4:0] == 5'd0) ? 5'd1 : item.write_data[4:0];
		low_cur   = (st.rom_bank[4:0] == 5'd0) ? 5'd1 : st.rom_bank[4:0];

		mo.res.read_data   = 8'd0;
		mo.res.rom_fetch   = 1'b0;
		mo.res.rom_address = 21'd0;
		mo.res.status      = 1'b1;
		mo.ram_read        = 1'b0;
		mo.ram_we          = 1'b0;
		mo.ram_addr        = ram_a[RAM_AW-1:0];
		mo.next            = st;

		if (item.command == CMD_READ) begin
			unique case (item.address[15:13])
				REGION_RAM_EN, REGION_ROM_LOW: begin
					mo.res.rom_fetch   = 1'b1;
					mo.res.rom_address = {5'd0, item.address};
					mo.res.status      = 1'b0;
				end
				REGION_RAM_BANK, REGION_MODE: begin
					if (rom_ok) begin
						mo.res.rom_fetch   = 1'b1;
						mo.res.rom_address = {st.rom_bank, item.address[13:0]};
						mo.res.status      = 1'b0;
					end else begin
						mo.res.read_data = OPEN_BUS;
					end
				end
				REGION_EXT_RAM: begin
					if (ram_ok) begin
						mo.ram_read   = 1'b1;
						mo.res.status = 1'b0;
					end else begin
						mo.res.read_data = OPEN_BUS;
					end
				end
				default: begin
					mo.res.read_data = OPEN_BUS;
				end
			endcase
		end else begin
			unique case (item.address[15:13])
				REGION_RAM_EN: begin
					mo.next.ram_enabled = (item.write_data[3:0] == RAM_EN_KEY);
					mo.res.status       = 1'b0;
				end
				REGION_ROM_LOW: begin
					mo.next.rom_bank = fit_bank(st.rom_mode ? {st.ram_bank, low_wr}
						: {2'd0, low_wr}, bank_mask);
					mo.res.status    = 1'b0;
				end
				REGION_RAM_BANK: begin
					mo.next.ram_bank = item.write_data[1:0];
					if (st.rom_mode) begin
						mo.next.rom_bank = fit_bank({item.write_data[1:0], low_cur}, bank_mask);
					end
					mo.res.status = 1'b0;
				end
				REGION_MODE: begin
					mo.next.rom_mode = !item.write_data[0];
					mo.res.status    = 1'b0;
				end
				REGION_EXT_RAM: begin
					if (ram_ok) begin
						mo.ram_we     = 1'b1;
						mo.res.status = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/cartridge_bank_mapper_top.sv
// Cartridge bank mapper: one bus access in, one result out.
// access channel: command (0 read, 1 write), address, write_data; a transfer
// takes place when valid and ready are both high. result channel: read_data,
// rom_fetch, rom_address, status, with the same handshake.
// An access is registered in the decode stage on its transfer and decoded there
// against the mapper state; its result is registered in the result register
// when that register is free or draining, and result valid comes from it. The
// external RAM read goes through the registered read port of the RAM, timed
// with the result register. One access per cycle is taken and one result per
// cycle is given while the receiver does not stall; the single pass through
// the decode stage sets that rate.
// Mapper state (RAM enable, ROM bank, RAM bank, mode) updates as each access
// leaves the decode stage, so the next access sees it at once.
// When the receiver stalls, the result register holds and the decode stage
// fills; ready drops only when both stages are full and the receiver stalls.
// Reset clears the stages and sets RAM disabled, ROM bank 1, RAM bank 0, ROM
// banking mode, rom_banks_log2 1 and ram_size 0. External RAM is not cleared;
// its contents are undefined until written.
// Configuration (wr_en, wr_index, wr_data) is to be written by the user only while idle; the block does not enforce it.
`default_nettype none
`include "assert_macros.svh"

module cartridge_bank_mapper_top import cbm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cbm_access_if.sink access,
	cbm_result_if.source result,
	input  wire logic  wr_en,
	input  wire logic  wr_index,
	input  wire logic [15:0] wr_data
);

	// configuration
	logic [2:0]  rom_banks_log2_q;
	logic [15:0] ram_size_q;

	// mapper state
	map_state_t state_q;

	// pipeline
	logic    valid_s1;
	access_t item_s1;
	logic    valid_s2;
	result_t res_s2;
	logic    ram_rd_s2;

	map_out_t   mo;
	logic       adv2;
	logic       take;
	logic [7:0] ram_rdata;

	// Advance the decode stage when the result register is free or draining.
	assign adv2         = valid_s1 && (!valid_s2 || result.ready);
	assign access.ready = !valid_s1 || adv2;
	assign take         = access.valid && access.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_banks_log2_q <= 3'd1;
			ram_size_q       <= 16'd0;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_ROM_BANKS_LOG2: rom_banks_log2_q <= wr_data[2:0];
				REG_RAM_SIZE:       ram_size_q       <= wr_data;
			endcase
		end
	end

	// Hold the accepted access for the decode stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.command    <= access.command;
			item_s1.address    <= access.address;
			item_s1.write_data <= access.write_data;
		end
	end

	cbm_map u_map (
		.item           (item_s1),
		.st             (state_q),
		.rom_banks_log2 (rom_banks_log2_q),
		.ram_size       (ram_size_q),
		.mo             (mo)
	);

	// Commit the state update as the access leaves the decode stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.ram_enabled <= 1'b0;
			state_q.rom_bank    <= 7'd1;
			state_q.ram_bank    <= 2'd0;
			state_q.rom_mode    <= 1'b1;
		end else if (adv2) begin
			state_q <= mo.next;
		end
	end

	cbm_ram #(
		.WIDTH (8),
		.DEPTH (RAM_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (adv2 && mo.ram_we),
		.waddr (mo.ram_addr),
		.wdata (item_s1.write_data),
		.re    (adv2 && mo.ram_read),
		.raddr (mo.ram_addr),
		.rdata (ram_rdata)
	);

	// Result register; the RAM read data lands alongside it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			ram_rd_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2  <= 1'b1;
			ram_rd_s2 <= mo.ram_read;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			res_s2 <= mo.res;
		end
	end

	assign result.valid       = valid_s2;
	assign result.read_data   = ram_rd_s2 ? ram_rdata : res_s2.read_data;
	assign result.rom_fetch   = res_s2.rom_fetch;
	assign result.rom_address = res_s2.rom_address;
	assign result.status      = res_s2.status;

	`ASSERT_NEVER(a_bank_nonzero, clk, arst_n, state_q.rom_bank == 7'd0)
	`ASSERT_ON(a_ram_we_enabled, clk, arst_n, (adv2 && mo.ram_we) |-> state_q.ram_enabled)
	`ASSERT_ON(a_ram_read_lands, clk, arst_n, (adv2 && mo.ram_read) |=> (valid_s2 && ram_rd_s2))
	`ASSERT_ON(a_fetch_clean, clk, arst_n, (valid_s2 && res_s2.rom_fetch) |-> !ram_rd_s2)
	`ASSERT_ON(a_stall_hold, clk, arst_n, (valid_s2 && !result.ready) |=> (valid_s2 && $stable(res_s2)))

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import cbm_pkg::*;

	// Clock cycles without a transfer before the run is declared hung. The slowest
	// correct item (sender gap, passage through the mapper, receiver stall) and
	// the idle pauses between phases stay inside this limit.
	localparam int STALL_LIMIT = 1000;
	localparam int PHASE_ITEMS = 100;
	localparam int PHASES      = 10;
	localparam int DRAIN_WAIT  = 6;

	// Mirror of the mapper: its registers, its state and an image of the
	// external RAM. It keeps the results still owed by the block.
	class map_scoreboard;
		logic [2:0]  banks_log2;
		logic [15:0] ram_bytes_cfg;
		logic        ram_enabled;
		logic [6:0]  rom_bank;
		logic [1:0]  ram_bank;
		logic        rom_mode;
		logic [7:0]  ram_image [RAM_BYTES];
		bit          written [RAM_BYTES];
		result_t     pending_results [$];
		int          mismatches;

		function new();
			banks_log2    = 3'd1;
			ram_bytes_cfg = 16'd0;
			ram_enabled   = 1'b0;
			rom_bank      = 7'd1;
			ram_bank      = 2'd0;
			rom_mode      = 1'b1;
			mismatches    = 0;
		endfunction

		function void set_reg(reg_index_t idx, logic [15:0] value);
			if (idx == REG_ROM_BANKS_LOG2) begin
				banks_log2 = value[2:0];
			end else begin
				ram_bytes_cfg = value;
			end
		endfunction

		// Wrap a bank into the ROM present; bank 0 reads as bank 1.
		function logic [6:0] fit_bank(logic [6:0] bank);
			logic [6:0] masked;
			masked = bank & 7'((8'd1 << banks_log2) - 8'd1);
			return (masked == 7'd0) ? 7'd1 : masked;
		endfunction

		function int unsigned ram_offset(logic [15:0] addr);
			return int'(ram_bank) * 32'h2000 + int'(addr[12:0]);
		endfunction

		function bit ram_hit(logic [15:0] addr);
			int unsigned limit;
			limit = (ram_bytes_cfg > RAM_BYTES) ? RAM_BYTES : int'(ram_bytes_cfg);
			return ram_enabled && (ram_offset(addr) < limit);
		endfunction

		function bit reads_unwritten(access_t a);
			return a.command == CMD_READ && a.address[15:13] == REGION_EXT_RAM &&
				ram_hit(a.address) && !written[ram_offset(a.address)];
		endfunction

		// Work out the result of one access and apply its effect on the state.
		function void map_access(access_t a);
			result_t     r;
			logic [4:0]  low;
			int unsigned phys;
			int unsigned rom_bytes;
			r = '0;
			r.status = 1'b1;
			if (a.command == CMD_READ) begin
				r.read_data = OPEN_BUS;
				case (a.address[15:13])
					REGION_RAM_EN, REGION_ROM_LOW: begin
						r.read_data   = 8'h00;
						r.rom_fetch   = 1'b1;
						r.rom_address = {5'd0, a.address};
						r.status      = 1'b0;
					end
					REGION_RAM_BANK, REGION_MODE: begin
						phys      = int'(rom_bank) * 32'h4000 + int'(a.address[13:0]);
						rom_bytes = 32'h4000 << banks_log2;
						if (phys < rom_bytes) begin
							r.read_data   = 8'h00;
							r.rom_fetch   = 1'b1;
							r.rom_address = phys[20:0];
							r.status      = 1'b0;
						end
					end
					REGION_EXT_RAM: begin
						if (ram_hit(a.address)) begin
							r.read_data = ram_image[ram_offset(a.address)];
							r.status    = 1'b0;
						end
					end
					default: ;
				endcase
			end else begin
				case (a.address[15:13])
					REGION_RAM_EN: begin
						ram_enabled = (a.write_data[3:0] == RAM_EN_KEY);
						r.status    = 1'b0;
					end
					REGION_ROM_LOW: begin
						low = a.write_data[4:0];
						if (low == 5'd0) low = 5'd1;
						rom_bank = fit_bank(rom_mode ? {ram_bank, low} : {2'b00, low});
						r.status = 1'b0;
					end
					REGION_RAM_BANK: begin
						ram_bank = a.write_data[1:0];
						if (rom_mode) begin
							low = rom_bank[4:0];
							if (low == 5'd0) low = 5'd1;
							rom_bank = fit_bank({ram_bank, low});
						end
						r.status = 1'b0;
					end
					REGION_MODE: begin
						rom_mode = !a.write_data[0];
						r.status = 1'b0;
					end
					REGION_EXT_RAM: begin
						if (ram_hit(a.address)) begin
							ram_image[ram_offset(a.address)] = a.write_data;
							written[ram_offset(a.address)]   = 1'b1;
							r.status = 1'b0;
						end
					end
					default: ;
				endcase
			end
			pending_results.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$error("result with no access outstanding: read_data %h rom_address %h",
					got.read_data, got.rom_address);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (got.read_data !== want.read_data) begin
				$error("read_data: expected %h, got %h", want.read_data, got.read_data);
				mismatches++;
			end
			if (got.rom_fetch !== want.rom_fetch) begin
				$error("rom_fetch: expected %b, got %b", want.rom_fetch, got.rom_fetch);
				mismatches++;
			end
			if (got.rom_address !== want.rom_address) begin
				$error("rom_address: expected %h, got %h", want.rom_address, got.rom_address);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %b, got %b", want.status, got.status);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	reg_index_t  wr_index;
	logic [15:0] wr_data;

	cbm_access_if access_ch ();
	cbm_result_if result_ch ();

	cartridge_bank_mapper_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.access   (access_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	map_scoreboard sb = new();

	// While set, the side concerned runs back to back with no idle cycles.
	bit access_burst = 1'b0;
	bit result_burst = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one access, idle first for a random gap, and hold it until its
	// transfer. Valid is only lowered when a gap is taken, so back-to-back
	// transfers never see valid dropped and raised in the same step.
	task automatic send_access(access_t a);
		int gap;
		gap = access_burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			access_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		access_ch.valid      <= 1'b1;
		access_ch.command    <= a.command;
		access_ch.address    <= a.address;
		access_ch.write_data <= a.write_data;
		do @(posedge clk); while (!access_ch.ready);
		sb.map_access(a);
	endtask

	task automatic put(cmd_t cmd, logic [15:0] addr, logic [7:0] data);
		access_t a;
		a.command    = cmd;
		a.address    = addr;
		a.write_data = data;
		send_access(a);
	endtask

	// Drop valid, wait for every owed result, then let the pipeline settle.
	task automatic drain();
		access_ch.valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Registers change only with the mapper idle.
	task automatic configure(logic [2:0] log2_banks, logic [15:0] ram_bytes);
		drain();
		wr_en    <= 1'b1;
		wr_index <= REG_ROM_BANKS_LOG2;
		wr_data  <= 16'(log2_banks);
		@(posedge clk);
		sb.set_reg(REG_ROM_BANKS_LOG2, 16'(log2_banks));
		wr_index <= REG_RAM_SIZE;
		wr_data  <= ram_bytes;
		@(posedge clk);
		sb.set_reg(REG_RAM_SIZE, ram_bytes);
		wr_en <= 1'b0;
	endtask

	// Mostly well-formed traffic: control writes, RAM traffic aimed at a few
	// hot offsets so reads find written bytes, ROM reads, plus some noise.
	function automatic access_t random_access();
		access_t     a;
		int unsigned pick;
		logic [12:0] off;
		a.command    = CMD_WRITE;
		a.address    = 16'($urandom);
		a.write_data = 8'($urandom);
		case ($urandom_range(0, 2))
			0:       off = 13'($urandom_range(0, 63));
			1:       off = 13'h1FC0 + 13'($urandom_range(0, 63));
			default: off = 13'($urandom);
		endcase
		pick = $urandom_range(0, 99);
		if (pick < 14) begin
			a.address = {REGION_RAM_EN, 13'($urandom)};
			if ($urandom_range(0, 3) != 0) a.write_data[3:0] = RAM_EN_KEY;
		end else if (pick < 24) begin
			a.address = {REGION_ROM_LOW, 13'($urandom)};
		end else if (pick < 32) begin
			a.address = {REGION_RAM_BANK, 13'($urandom)};
		end else if (pick < 37) begin
			a.address = {REGION_MODE, 13'($urandom)};
		end else if (pick < 62) begin
			a.address = {REGION_EXT_RAM, off};
		end else if (pick < 77) begin
			a.command = CMD_READ;
			a.address = {REGION_EXT_RAM, off};
		end else if (pick < 92) begin
			a.command = CMD_READ;
			a.address = 16'($urandom_range(0, 16'h7FFF));
		end else begin
			a.command = cmd_t'($urandom_range(0, 1));
		end
		// Never read a RAM byte that has not been written: store to it instead.
		if (sb.reads_unwritten(a)) a.command = CMD_WRITE;
		return a;
	endfunction

	// Receiver: take every result, with random stalls in front of each.
	initial begin
		int      gap;
		result_t got;
		result_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0) result_burst = !result_burst;
			gap = result_burst ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			got.read_data   = result_ch.read_data;
			got.rom_fetch   = result_ch.rom_fetch;
			got.rom_address = result_ch.rom_address;
			got.status      = result_ch.status;
			sb.check_result(got);
		end
	end

	// Watchdog: end the run if no transfer happens for too long.
	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((access_ch.valid && access_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		logic [2:0]  log2_banks;
		logic [15:0] ram_bytes;
		access_ch.valid      <= 1'b0;
		access_ch.command    <= CMD_READ;
		access_ch.address    <= 16'h0000;
		access_ch.write_data <= 8'h00;
		wr_en                <= 1'b0;
		wr_index             <= REG_ROM_BANKS_LOG2;
		wr_data              <= 16'h0000;
		arst_n               <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset: two ROM banks, no RAM. Fixed and switched ROM reads at
		// their edges, RAM access with no RAM present, unmapped reads and writes.
		put(CMD_READ,  16'h0000, 8'h00);
		put(CMD_READ,  16'h3FFF, 8'hFF);
		put(CMD_READ,  16'h4000, 8'h00);
		put(CMD_READ,  16'h7FFF, 8'h00);
		put(CMD_WRITE, 16'h0000, 8'h0A);
		put(CMD_WRITE, 16'hA000, 8'h55);
		put(CMD_READ,  16'hA000, 8'h00);
		put(CMD_READ,  16'h8000, 8'h00);
		put(CMD_READ,  16'hFFFF, 8'hFF);
		put(CMD_WRITE, 16'hFFFF, 8'hFF);
		put(CMD_READ,  16'hC000, 8'h00);

		// Largest ROM and RAM: bank 0 read as 1, top bank and top RAM byte,
		// both banking modes, RAM disable.
		configure(3'd7, 16'd32768);
		put(CMD_WRITE, 16'h2000, 8'h00);
		put(CMD_WRITE, 16'h3FFF, 8'hFF);
		put(CMD_WRITE, 16'h4000, 8'h03);
		put(CMD_READ,  16'h7FFF, 8'h00);
		put(CMD_WRITE, 16'hBFFF, 8'hA5);
		put(CMD_READ,  16'hBFFF, 8'h00);
		put(CMD_WRITE, 16'h6000, 8'h01);
		put(CMD_WRITE, 16'h2000, 8'h20);
		put(CMD_WRITE, 16'h5FFF, 8'h00);
		put(CMD_WRITE, 16'hA000, 8'h00);
		put(CMD_READ,  16'hA000, 8'h00);
		put(CMD_WRITE, 16'h1FFF, 8'h00);
		put(CMD_READ,  16'hA000, 8'h00);
		put(CMD_WRITE, 16'h7FFF, 8'hFE);

		// Random phases. The bank register survives each change of ROM size,
		// so shrinking the ROM exposes out-of-range switched-bank reads.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin log2_banks = 3'd0; ram_bytes = 16'd32768; end
				1: begin log2_banks = 3'd7; ram_bytes = 16'd0; end
				2: begin log2_banks = 3'd3; ram_bytes = 16'd1; end
				3: begin log2_banks = 3'd7; ram_bytes = 16'd32768; end
				4: begin log2_banks = 3'd1; ram_bytes = 16'd2048; end
				default: begin
					log2_banks = 3'($urandom_range(0, 7));
					case ($urandom_range(0, 5))
						0:       ram_bytes = 16'd0;
						1:       ram_bytes = 16'd8192;
						2:       ram_bytes = 16'd16384;
						3:       ram_bytes = 16'd24576;
						4:       ram_bytes = 16'd32768;
						default: ram_bytes = 16'($urandom_range(0, 32768));
					endcase
				end
			endcase
			configure(log2_banks, ram_bytes);
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 39) == 0) access_burst = !access_burst;
				send_access(random_access());
			end
		end

		drain();
		if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
